// ===== design/fcs_pkg.sv =====
// fcs_pkg: shared types and constants of the flash command sequencer
// used by fcs_ctrl, fcs_datapath and flash_command_sequencer; no dependencies
package fcs_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_INIT,
        ST_FILL,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // command set modes
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_UNLOCK1  = 3'd1,
        MODE_UNLOCK2  = 3'd2,
        MODE_PROGRAM  = 3'd3,
        MODE_ERASE_U1 = 3'd4,
        MODE_ERASE_U2 = 3'd5,
        MODE_ERASE    = 3'd6
    } mode_t;

    // event codes reported with every result word
    typedef enum logic [1:0] {
        EV_OK      = 2'd0,
        EV_RESET   = 2'd1,
        EV_UNKNOWN = 2'd2
    } ev_t;

    // range of a fill with the erased value
    typedef enum logic [1:0] {
        FILL_ALL,
        FILL_LOW,
        FILL_SECTOR
    } fill_kind_t;

    // source of the read_data field
    typedef enum logic [1:0] {
        RD_MEM,
        RD_STATUS,
        RD_ZERO
    } rd_sel_t;

    // command addresses and data bytes
    localparam logic [19:0] ADDR_UNLOCK_A  = 20'h00AAA;
    localparam logic [19:0] ADDR_UNLOCK_B  = 20'h00555;
    localparam logic [19:0] ADDR_SECTOR_2  = 20'h20000;
    localparam logic [19:0] ADDR_SECTOR_3  = 20'h30000;
    localparam logic [19:0] LOW_FILL_LAST  = 20'h07FFF;
    localparam logic [15:0] SECTOR_LAST    = 16'hFFFF;
    localparam logic [7:0]  DATA_UNLOCK_A  = 8'hAA;
    localparam logic [7:0]  DATA_UNLOCK_B  = 8'h55;
    localparam logic [7:0]  DATA_PROGRAM   = 8'hA0;
    localparam logic [7:0]  DATA_ERASE     = 8'h80;
    localparam logic [7:0]  DATA_RESET     = 8'hF0;
    localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
    localparam logic [7:0]  ERASE_STATUS   = 8'h80;
    localparam logic [7:0]  WRITE_READBACK = 8'h00;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       prog_we;
        logic       fill_start;
        fill_kind_t fill_kind;
        logic       fill_step;
        logic       load_out;
        rd_sel_t    rd_sel;
        ev_t        ev;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_write;
        logic addr_unlock_a;
        logic addr_unlock_b;
        logic addr_zero;
        logic addr_sector;
        logic data_unlock_a;
        logic data_unlock_b;
        logic data_program;
        logic data_erase;
        logic data_reset;
        logic fill_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/fcs_datapath.sv =====
// fcs_datapath: byte store, captured access word, fill sweep and output register
// depends on fcs_pkg; driven by fcs_ctrl
module fcs_datapath
    import fcs_pkg::*;
#(
    parameter int ADDR_BITS = 19
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd,
    input  logic [7:0]  seg,
    input  logic [15:0] offset,
    input  logic [7:0]  write_data,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  read_data,
    output logic [1:0]  event_res,
    input  dp_cmd_t     dp_cmd,
    output dp_stat_t    dp_stat
);

    localparam logic [ADDR_BITS-1:0] A_UNLOCK_A = ADDR_BITS'(ADDR_UNLOCK_A);
    localparam logic [ADDR_BITS-1:0] A_UNLOCK_B = ADDR_BITS'(ADDR_UNLOCK_B);
    localparam logic [ADDR_BITS-1:0] A_SECTOR_2 = ADDR_BITS'(ADDR_SECTOR_2);
    localparam logic [ADDR_BITS-1:0] A_SECTOR_3 = ADDR_BITS'(ADDR_SECTOR_3);
    localparam logic [ADDR_BITS-1:0] A_LOW_LAST = ADDR_BITS'(LOW_FILL_LAST);

    logic [7:0]           mem [2**ADDR_BITS];
    logic [ADDR_BITS-1:0] in_addr;
    logic                 cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [7:0]           data_reg;
    logic [7:0]           rd_data_reg;
    logic [ADDR_BITS-1:0] fill_addr_reg;
    logic [ADDR_BITS-1:0] fill_last_reg;
    logic                 out_valid_reg;
    logic [7:0]           read_data_reg;
    logic [1:0]           event_reg;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [7:0]           mem_wdata;
    logic [7:0]           out_byte;

    // byte address: segment above offset, masked to the store size
    assign in_addr = ADDR_BITS'({seg, offset});

    // captured access word
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= cmd;
            addr_reg <= in_addr;
            data_reg <= write_data;
        end
    end

    // store write port shared by program and fill, read port at capture
    assign mem_we    = dp_cmd.prog_we | dp_cmd.fill_step;
    assign mem_waddr = dp_cmd.prog_we ? addr_reg : fill_addr_reg;
    assign mem_wdata = dp_cmd.prog_we ? data_reg : ERASED_BYTE;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (dp_cmd.capture)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    // fill sweep range and pointer
    always_ff @(posedge clk)
    begin
        if (dp_cmd.fill_start)
        begin
            unique case (dp_cmd.fill_kind)
                FILL_ALL:
                begin
                    fill_addr_reg <= '0;
                    fill_last_reg <= '1;
                end
                FILL_LOW:
                begin
                    fill_addr_reg <= '0;
                    fill_last_reg <= A_LOW_LAST;
                end
                FILL_SECTOR:
                begin
                    fill_addr_reg <= addr_reg;
                    fill_last_reg <= {addr_reg[ADDR_BITS-1:16], SECTOR_LAST};
                end
                default:
                begin
                    fill_addr_reg <= '0;
                    fill_last_reg <= '1;
                end
            endcase
        end
        else if (dp_cmd.fill_step)
        begin
            fill_addr_reg <= fill_addr_reg + 1'b1;
        end
    end

    // result byte selection
    always_comb
    begin
        unique case (dp_cmd.rd_sel)
            RD_MEM:    out_byte = rd_data_reg;
            RD_STATUS: out_byte = ERASE_STATUS;
            RD_ZERO:   out_byte = WRITE_READBACK;
            default:   out_byte = WRITE_READBACK;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            read_data_reg <= out_byte;
            event_reg     <= dp_cmd.ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign event_res = event_reg;

    // status towards the controller
    always_comb
    begin
        dp_stat.is_write      = cmd_reg;
        dp_stat.addr_unlock_a = (addr_reg == A_UNLOCK_A);
        dp_stat.addr_unlock_b = (addr_reg == A_UNLOCK_B);
        dp_stat.addr_zero     = (addr_reg == '0);
        dp_stat.addr_sector   = (addr_reg == A_SECTOR_2) || (addr_reg == A_SECTOR_3);
        dp_stat.data_unlock_a = (data_reg == DATA_UNLOCK_A);
        dp_stat.data_unlock_b = (data_reg == DATA_UNLOCK_B);
        dp_stat.data_program  = (data_reg == DATA_PROGRAM);
        dp_stat.data_erase    = (data_reg == DATA_ERASE);
        dp_stat.data_reset    = (data_reg == DATA_RESET);
        dp_stat.fill_done     = (fill_addr_reg == fill_last_reg);
        dp_stat.out_free      = !out_valid_reg || !out_stall;
    end

endmodule

// ===== design/fcs_ctrl.sv =====
// fcs_ctrl: sequencing state machine and command set mode machine
// depends on fcs_pkg; drives fcs_datapath through dp_cmd_t
module fcs_ctrl
    import fcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    state_t state_reg;
    state_t state_next;
    mode_t  mode_reg;
    mode_t  mode_next;
    logic   matched;

    // state and mode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            mode_reg  <= MODE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // next state, mode update and datapath commands
    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        matched           = 1'b0;
        in_stall          = 1'b1;
        dp_cmd.capture    = 1'b0;
        dp_cmd.prog_we    = 1'b0;
        dp_cmd.fill_start = 1'b0;
        dp_cmd.fill_kind  = FILL_ALL;
        dp_cmd.fill_step  = 1'b0;
        dp_cmd.load_out   = 1'b0;
        dp_cmd.rd_sel     = RD_MEM;
        dp_cmd.ev         = EV_OK;

        unique case (state_reg)
            ST_INIT:
            begin
                // erase the whole store after reset
                dp_cmd.fill_start = 1'b1;
                dp_cmd.fill_kind  = FILL_ALL;
                state_next        = ST_FILL;
            end
            ST_FILL:
            begin
                dp_cmd.fill_step = 1'b1;
                if (dp_stat.fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = ST_IDLE;
                    if (!dp_stat.is_write)
                    begin
                        // read: status in erase mode, else stored byte
                        if (mode_reg == MODE_ERASE)
                        begin
                            dp_cmd.rd_sel = RD_STATUS;
                            mode_next     = MODE_IDLE;
                        end
                        else
                        begin
                            dp_cmd.rd_sel = RD_MEM;
                        end
                    end
                    else
                    begin
                        dp_cmd.rd_sel = RD_ZERO;
                        unique case (mode_reg)
                            MODE_UNLOCK1:
                            begin
                                if (dp_stat.addr_unlock_b && dp_stat.data_unlock_b)
                                begin
                                    matched   = 1'b1;
                                    mode_next = MODE_UNLOCK2;
                                end
                            end
                            MODE_UNLOCK2:
                            begin
                                if (dp_stat.addr_unlock_a && dp_stat.data_program)
                                begin
                                    matched   = 1'b1;
                                    mode_next = MODE_PROGRAM;
                                end
                                else if (dp_stat.addr_unlock_a && dp_stat.data_erase)
                                begin
                                    matched   = 1'b1;
                                    mode_next = MODE_ERASE_U1;
                                end
                            end
                            MODE_PROGRAM:
                            begin
                                matched        = 1'b1;
                                dp_cmd.prog_we = 1'b1;
                                mode_next      = MODE_IDLE;
                            end
                            MODE_ERASE_U1:
                            begin
                                if (dp_stat.addr_unlock_a && dp_stat.data_unlock_a)
                                begin
                                    matched   = 1'b1;
                                    mode_next = MODE_ERASE_U2;
                                end
                            end
                            MODE_ERASE_U2:
                            begin
                                if (dp_stat.addr_unlock_b && dp_stat.data_unlock_b)
                                begin
                                    matched   = 1'b1;
                                    mode_next = MODE_ERASE;
                                end
                            end
                            MODE_ERASE:
                            begin
                                // low or sector erase sweeps, input held off
                                matched = 1'b1;
                                if (dp_stat.addr_zero)
                                begin
                                    dp_cmd.fill_start = 1'b1;
                                    dp_cmd.fill_kind  = FILL_LOW;
                                    state_next        = ST_FILL;
                                end
                                else if (dp_stat.addr_sector)
                                begin
                                    dp_cmd.fill_start = 1'b1;
                                    dp_cmd.fill_kind  = FILL_SECTOR;
                                    state_next        = ST_FILL;
                                end
                            end
                            default:
                            begin
                                // idle and the unused mode code
                                if (dp_stat.addr_unlock_a && dp_stat.data_unlock_a)
                                begin
                                    matched   = 1'b1;
                                    mode_next = MODE_UNLOCK1;
                                end
                            end
                        endcase

                        // unmatched write: F0 resets, anything else is unknown
                        if (!matched)
                        begin
                            if (dp_stat.data_reset)
                            begin
                                mode_next = MODE_IDLE;
                                dp_cmd.ev = EV_RESET;
                            end
                            else
                            begin
                                dp_cmd.ev = EV_UNKNOWN;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== design/flash_command_sequencer.sv =====
// flash_command_sequencer: NOR flash command interface over a byte store
// an access word is captured on acceptance, then decoded, and its result word is loaded into the
// output register once the output is free; no new word is accepted until that result is loaded
// erase holds off input while the fill sweeps the low range or a sector of the store
// reset: mode goes idle, then a clearing pass erases the whole store
module flash_command_sequencer
    import fcs_pkg::*;
#(
    parameter int ADDR_BITS = 19
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  seg,
    input  logic [15:0] offset,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [1:0]  event_res
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // controller
    fcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    // datapath
    fcs_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .seg        (seg),
        .offset     (offset),
        .write_data (write_data),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .read_data  (read_data),
        .event_res  (event_res),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat)
    );

endmodule
